@@ rtl/pfsf_pkg.sv @@
package pfsf_pkg;

    localparam int COUNT_W   = 31;
    localparam int M_TDATA_W = 40;
    localparam int S_TUSER_W = 3;
    localparam int NULL_LEN  = 6;

    localparam logic [1:0] OP_FMT = 2'd0;
    localparam logic [1:0] OP_STR = 2'd1;
    localparam logic [1:0] OP_END = 2'd2;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_X       = 8'h78;

    localparam logic [7:0] HEX_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    localparam logic [7:0] NULL_TEXT [NULL_LEN] = '{
        8'h28, 8'h6e, 8'h75, 8'h6c, 8'h6c, 8'h29
    };

    localparam logic [2:0] NULL_LAST = 3'(NULL_LEN - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DABBLE,
        ST_STRIP,
        ST_DIGIT,
        ST_NULL
    } t_state;

    typedef enum logic [2:0] {
        CONV_HOLD,
        CONV_LOAD_DEC,
        CONV_LOAD_HEX,
        CONV_DABBLE,
        CONV_SHIFT
    } t_conv_op;

    typedef struct packed {
        logic [3:0] digit;
        logic       dabble_done;
        logic       last_digit;
    } t_conv_stat;

endpackage

@@ rtl/pfsf_conv.sv @@
module pfsf_conv #(
    parameter int ARG_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pfsf_pkg::t_conv_op    i_cmd,
    input  logic [ARG_WIDTH-1:0]  i_word,
    output pfsf_pkg::t_conv_stat  o_stat
);

    localparam int BUF_DIGITS = (ARG_WIDTH * 3 + 9) / 10;
    localparam int NB         = BUF_DIGITS * 4;
    localparam int BITS_W     = $clog2(ARG_WIDTH + 1);
    localparam int LEFT_W     = $clog2(BUF_DIGITS + 1);

    logic [NB-1:0]        r_buf;
    logic [ARG_WIDTH-1:0] r_mag;
    logic [BITS_W-1:0]    r_bits;
    logic [LEFT_W-1:0]    r_left;
    logic [NB-1:0]        adj;

    always_comb begin
        for (int i = 0; i < BUF_DIGITS; i++) begin
            adj[i*4 +: 4] = (r_buf[i*4 +: 4] >= 4'd5) ? r_buf[i*4 +: 4] + 4'd3
                                                       : r_buf[i*4 +: 4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_left <= '0;
        end else begin
            unique case (i_cmd)
                pfsf_pkg::CONV_LOAD_DEC: begin
                    r_mag  <= i_word[ARG_WIDTH-1] ? ARG_WIDTH'(~i_word + 1'b1) : i_word;
                    r_buf  <= '0;
                    r_bits <= BITS_W'(ARG_WIDTH);
                    r_left <= LEFT_W'(BUF_DIGITS);
                end
                pfsf_pkg::CONV_LOAD_HEX: begin
                    r_buf  <= NB'(i_word);
                    r_bits <= '0;
                    r_left <= LEFT_W'(BUF_DIGITS);
                end
                pfsf_pkg::CONV_DABBLE: begin
                    r_buf  <= {adj[NB-2:0], r_mag[ARG_WIDTH-1]};
                    r_mag  <= {r_mag[ARG_WIDTH-2:0], 1'b0};
                    r_bits <= r_bits - 1'b1;
                end
                pfsf_pkg::CONV_SHIFT: begin
                    r_buf  <= {r_buf[NB-5:0], 4'h0};
                    r_left <= r_left - 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_stat.digit       = r_buf[NB-1 -: 4];
    assign o_stat.dabble_done = (r_bits == '0);
    assign o_stat.last_digit  = (r_left == LEFT_W'(1));

endmodule

@@ rtl/printf_format_stream_formatter.sv @@
// Format-string stream formatter: a printf subset with %d, %x and %s.
// Slave channel i_s_*: one item per format byte, string argument byte or end
// mark; tuser carries the opcode and the null flag, tlast marks the string
// terminator. Master channel o_m_*: one item per emitted character, or the
// count report (tuser low) for an end item; tlast marks the last item caused
// by one input item.
// Latency: a plain character, a string byte or the end report is registered
// at the accept edge and shows on the next cycle; such items go back to back while the receiver takes them.
// %x strips the leading zero digits of the digit buffer (ten digits with
// ARG_WIDTH 32), then emits one digit per cycle while the receiver takes
// them. %d first runs the shared shift-and-adjust unit over all ARG_WIDTH
// bits, then strips and emits the same way. A null string terminator emits
// "(null)".
// One item is in work at a time; tready is high only in the idle state with
// room in the output register.
// A stalled receiver holds the output register; the sequencer then waits at
// its next character.
// Reset clears the pending percent, the open string argument and the count.
module printf_format_stream_formatter #(
    parameter int ARG_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [((ARG_WIDTH + 15) / 8) * 8-1:0] i_s_tdata,  // data_byte, arg_word, zero pad
    input  logic [pfsf_pkg::S_TUSER_W-1:0]        i_s_tuser,  // opcode[1:0], string_null
    input  logic                                  i_s_tlast,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [pfsf_pkg::M_TDATA_W-1:0]        o_m_tdata,  // out_char, out_count, zero pad
    output logic                                  o_m_tuser,  // char_valid
    output logic                                  o_m_tlast
);

    localparam int CW = pfsf_pkg::COUNT_W;

    pfsf_pkg::t_state     r_state, n_state;
    pfsf_pkg::t_conv_op   conv_cmd;
    pfsf_pkg::t_conv_stat stat;

    logic          r_after, n_after;
    logic          r_str, n_str;
    logic [2:0]    r_idx, n_idx;
    logic [CW-1:0] r_count, n_count;

    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_out_cv;
    logic          r_out_last;
    logic [CW-1:0] r_out_count;

    logic                 s_acc, can_emit, emit, emit_cv, emit_last, clr;
    logic [7:0]           emit_char;
    logic [CW-1:0]        count_inc;
    logic [1:0]           w_opcode;
    logic [7:0]           w_byte;
    logic [ARG_WIDTH-1:0] w_word;
    logic                 w_null, w_end;

    assign w_opcode = i_s_tuser[1:0];
    assign w_null   = i_s_tuser[2];
    assign w_end    = i_s_tlast;
    assign w_byte   = i_s_tdata[7:0];
    assign w_word   = i_s_tdata[ARG_WIDTH+7:8];

    assign can_emit   = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == pfsf_pkg::ST_IDLE) && can_emit;
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign count_inc  = (r_count == {CW{1'b1}}) ? r_count : r_count + 1'b1;

    pfsf_conv #(
        .ARG_WIDTH (ARG_WIDTH)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (conv_cmd),
        .i_word  (w_word),
        .o_stat  (stat)
    );

    always_comb begin
        n_state   = r_state;
        n_after   = r_after;
        n_str     = r_str;
        n_idx     = r_idx;
        conv_cmd  = pfsf_pkg::CONV_HOLD;
        emit      = 1'b0;
        emit_char = w_byte;
        emit_cv   = 1'b1;
        emit_last = 1'b1;
        clr       = 1'b0;
        unique case (r_state)
            pfsf_pkg::ST_IDLE: begin
                if (s_acc) begin
                    unique case (w_opcode)
                        pfsf_pkg::OP_FMT: begin
                            if (w_byte != 8'h00) begin
                                n_str = 1'b0;
                                if (r_after) begin
                                    n_after = 1'b0;
                                    if (w_byte == pfsf_pkg::CH_S) begin
                                        n_str = 1'b1;
                                    end else if (w_byte == pfsf_pkg::CH_D) begin
                                        conv_cmd = pfsf_pkg::CONV_LOAD_DEC;
                                        n_state  = pfsf_pkg::ST_DABBLE;
                                        if (w_word[ARG_WIDTH-1]) begin
                                            emit      = 1'b1;
                                            emit_char = pfsf_pkg::CH_MINUS;
                                            emit_last = 1'b0;
                                        end
                                    end else if (w_byte == pfsf_pkg::CH_X) begin
                                        conv_cmd = pfsf_pkg::CONV_LOAD_HEX;
                                        n_state  = pfsf_pkg::ST_STRIP;
                                    end else begin
                                        emit = 1'b1;
                                    end
                                end else if (w_byte == pfsf_pkg::CH_PERCENT) begin
                                    n_after = 1'b1;
                                end else begin
                                    emit = 1'b1;
                                end
                            end
                        end
                        pfsf_pkg::OP_STR: begin
                            if (r_str) begin
                                if (w_end) begin
                                    n_str = 1'b0;
                                    if (w_null) begin
                                        n_state = pfsf_pkg::ST_NULL;
                                        n_idx   = '0;
                                    end
                                end else if (w_byte != 8'h00) begin
                                    emit = 1'b1;
                                end
                            end
                        end
                        pfsf_pkg::OP_END: begin
                            emit      = 1'b1;
                            emit_char = 8'h00;
                            emit_cv   = 1'b0;
                            clr       = 1'b1;
                            n_after   = 1'b0;
                            n_str     = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            pfsf_pkg::ST_DABBLE: begin
                if (stat.dabble_done) begin
                    n_state = pfsf_pkg::ST_STRIP;
                end else begin
                    conv_cmd = pfsf_pkg::CONV_DABBLE;
                end
            end
            pfsf_pkg::ST_STRIP: begin
                if (stat.digit == 4'h0 && !stat.last_digit) begin
                    conv_cmd = pfsf_pkg::CONV_SHIFT;
                end else begin
                    n_state = pfsf_pkg::ST_DIGIT;
                end
            end
            pfsf_pkg::ST_DIGIT: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_char = pfsf_pkg::HEX_CHARS[stat.digit];
                    emit_last = stat.last_digit;
                    if (stat.last_digit) begin
                        n_state = pfsf_pkg::ST_IDLE;
                    end else begin
                        conv_cmd = pfsf_pkg::CONV_SHIFT;
                    end
                end
            end
            pfsf_pkg::ST_NULL: begin
                if (can_emit) begin
                    emit      = 1'b1;
                    emit_char = pfsf_pkg::NULL_TEXT[r_idx];
                    emit_last = (r_idx == pfsf_pkg::NULL_LAST);
                    if (r_idx == pfsf_pkg::NULL_LAST) begin
                        n_state = pfsf_pkg::ST_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: n_state = pfsf_pkg::ST_IDLE;
        endcase

        if (clr) begin
            n_count = '0;
        end else if (emit && emit_cv) begin
            n_count = count_inc;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pfsf_pkg::ST_IDLE;
            r_after     <= 1'b0;
            r_str       <= 1'b0;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_str   <= n_str;
            r_idx   <= n_idx;
            r_count <= n_count;
            if (can_emit) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char  <= emit_char;
            r_out_cv    <= emit_cv;
            r_out_last  <= emit_last;
            r_out_count <= emit_cv ? count_inc : r_count;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_count, r_out_char};
    assign o_m_tuser  = r_out_cv;
    assign o_m_tlast  = r_out_last;

    a_end_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && w_opcode == pfsf_pkg::OP_END |=> r_count == '0 && !r_after && !r_str)
        else $error("end item did not clear state");

    a_report_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tlast)
        else $error("count report not marked last");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != pfsf_pkg::ST_IDLE |-> !o_s_tready)
        else $error("ready while converting");

    a_last_digit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit && r_state == pfsf_pkg::ST_DIGIT && stat.last_digit
        |=> r_state == pfsf_pkg::ST_IDLE)
        else $error("sequencer did not return to idle after last digit");

    a_dabble_to_strip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pfsf_pkg::ST_DABBLE && stat.dabble_done |=> r_state == pfsf_pkg::ST_STRIP)
        else $error("conversion did not advance to strip");

endmodule
